/* sv/ntr_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and sizing constants of the note take recorder.
// Used by ntr_front, ntr_back, note_take_recorder and ntr_checker; depends on nothing.
package ntr_pkg;

   localparam int MAX_EVENTS = 1024;
   localparam int KEY_COUNT  = 128;
   localparam int QDEPTH     = 2;

   localparam int EV_W    = $clog2(MAX_EVENTS);
   localparam int CNT_W   = $clog2(MAX_EVENTS + 1);
   localparam int HELD_W  = $clog2(KEY_COUNT + 1);
   localparam int KEY_W   = 7;
   localparam int VEL_W   = 7;
   localparam int TIME_W  = 32;
   localparam int IDX_W   = 10;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QLVL_W  = $clog2(QDEPTH + 1);
   localparam int KEY_SPACE = 2 ** KEY_W;

   localparam logic [2:0] MODE_NOTE_ON  = 3'd0;
   localparam logic [2:0] MODE_NOTE_OFF = 3'd1;
   localparam logic [2:0] MODE_FINISH   = 3'd2;
   localparam logic [2:0] MODE_CLEAR    = 3'd3;
   localparam logic [2:0] MODE_READ     = 3'd4;

   typedef enum logic [2:0] {
      STAT_RECORDED     = 3'd0,
      STAT_DROP_CAP     = 3'd1,
      STAT_DROP_NOTHELD = 3'd2,
      STAT_DONE         = 3'd3,
      STAT_READ_RANGE   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      OP_ON     = 3'd0,
      OP_OFF    = 3'd1,
      OP_FINISH = 3'd2,
      OP_CLEAR  = 3'd3,
      OP_READ   = 3'd4,
      OP_NONE   = 3'd5
   } op_type;

   typedef struct packed {
      op_type             op;
      logic               key_ok;
      logic [KEY_W-1:0]   note_key;
      logic [VEL_W-1:0]   note_velocity;
      logic [TIME_W-1:0]  time_ms;
      logic [IDX_W-1:0]   read_index;
   } cmd_type;

   typedef struct packed {
      logic [TIME_W-1:0] time_ms;
      logic [KEY_W-1:0]  note_key;
      logic [VEL_W-1:0]  note_velocity;
      logic              is_off;
   } event_type;

endpackage

/* sv/ntr_front.sv */
`timescale 1ns / 1ps
// Front end of the note take recorder: takes requests, decodes them into commands
// and holds them in a short queue for the back end. Depends on ntr_pkg.
module ntr_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [2:0]                      req_mode,
   input  logic [ntr_pkg::KEY_W-1:0]       req_note_key,
   input  logic [ntr_pkg::VEL_W-1:0]       req_note_velocity,
   input  logic [ntr_pkg::TIME_W-1:0]      req_time_ms,
   input  logic [ntr_pkg::IDX_W-1:0]       req_read_index,
   output logic                            cmd_valid,
   input  logic                            cmd_pop,
   output ntr_pkg::cmd_type                cmd
);

   ntr_pkg::cmd_type              q_ff [ntr_pkg::QDEPTH];
   logic [ntr_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [ntr_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [ntr_pkg::QLVL_W-1:0]    level_ff, level_in;
   ntr_pkg::cmd_type              dec;
   logic                          push;

   always_comb begin
      dec.note_key      = req_note_key;
      dec.note_velocity = req_note_velocity;
      dec.time_ms       = req_time_ms;
      dec.read_index    = req_read_index;
      dec.key_ok        = (32'(req_note_key) < 32'(ntr_pkg::KEY_COUNT));
      case (req_mode)
         ntr_pkg::MODE_NOTE_ON:  dec.op = ntr_pkg::OP_ON;
         ntr_pkg::MODE_NOTE_OFF: dec.op = ntr_pkg::OP_OFF;
         ntr_pkg::MODE_FINISH:   dec.op = ntr_pkg::OP_FINISH;
         ntr_pkg::MODE_CLEAR:    dec.op = ntr_pkg::OP_CLEAR;
         ntr_pkg::MODE_READ:     dec.op = ntr_pkg::OP_READ;
         default:                dec.op = ntr_pkg::OP_NONE;
      endcase
   end

   assign req_stall = (level_ff == ntr_pkg::QLVL_W'(ntr_pkg::QDEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (level_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == ntr_pkg::QPTR_W'(ntr_pkg::QDEPTH - 1)) ? '0
                     : wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == ntr_pkg::QPTR_W'(ntr_pkg::QDEPTH - 1)) ? '0
                     : rd_ptr_ff + 1'b1;
      end
      if (push && !cmd_pop) begin
         level_in = level_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

/* sv/ntr_back.sv */
`timescale 1ns / 1ps
// Back end of the note take recorder: executes queued commands against the held-key
// map and the event memory and drives the response register. Depends on ntr_pkg.
module ntr_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_valid,
   output logic                            cmd_pop,
   input  ntr_pkg::cmd_type                cmd,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [2:0]                      rsp_status,
   output logic [10:0]                     rsp_stored_count,
   output logic [31:0]                     rsp_take_length_ms,
   output logic [31:0]                     rsp_read_time,
   output logic [6:0]                      rsp_read_key,
   output logic [6:0]                      rsp_read_velocity,
   output logic                            rsp_read_is_off
);

   typedef enum logic [3:0] {
      BK_IDLE = 4'b0001,
      BK_READ = 4'b0010,
      BK_WALK = 4'b0100,
      BK_DONE = 4'b1000
   } bk_state_type;

   bk_state_type                       state_ff, state_in;
   logic [ntr_pkg::KEY_SPACE-1:0]      held_map_ff, held_map_in;
   logic [ntr_pkg::HELD_W-1:0]         held_total_ff, held_total_in;
   logic [ntr_pkg::CNT_W-1:0]          event_total_ff, event_total_in;
   logic [ntr_pkg::TIME_W-1:0]         take_len_ff, take_len_in;
   logic [ntr_pkg::KEY_W-1:0]          walk_key_ff, walk_key_in;
   logic [ntr_pkg::TIME_W-1:0]         fin_time_ff, fin_time_in;
   logic                               read_ok_ff, read_ok_in;

   ntr_pkg::event_type                 mem [ntr_pkg::MAX_EVENTS];
   ntr_pkg::event_type                 rd_data_ff;
   logic                               mem_we, mem_re;
   logic [ntr_pkg::EV_W-1:0]           mem_waddr, mem_raddr;
   ntr_pkg::event_type                 mem_wdata;

   logic                               rsp_valid_ff;
   ntr_pkg::status_type                status_ff, out_status;
   logic [10:0]                        count_ff;
   logic [31:0]                        take_ff;
   ntr_pkg::event_type                 rev_ff, out_event;
   logic                               out_load, out_free;

   logic                               held, newly, room, store_full, in_range;
   logic [ntr_pkg::CNT_W:0]            reserve;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign held       = held_map_ff[cmd.note_key];
   assign newly      = !held;
   assign reserve    = (ntr_pkg::CNT_W+1)'(event_total_ff)
                       + (ntr_pkg::CNT_W+1)'(held_total_ff)
                       + (ntr_pkg::CNT_W+1)'(newly) + 1'b1;
   assign room       = (reserve <= (ntr_pkg::CNT_W+1)'(ntr_pkg::MAX_EVENTS));
   assign store_full = (event_total_ff >= ntr_pkg::CNT_W'(ntr_pkg::MAX_EVENTS));
   assign in_range   = (32'(cmd.read_index) < 32'(event_total_ff))
                       && (32'(cmd.read_index) < 32'(ntr_pkg::MAX_EVENTS));
   assign mem_waddr  = event_total_ff[ntr_pkg::EV_W-1:0];
   assign mem_raddr  = ntr_pkg::EV_W'(cmd.read_index);

   always_comb begin
      state_in       = state_ff;
      held_map_in    = held_map_ff;
      held_total_in  = held_total_ff;
      event_total_in = event_total_ff;
      take_len_in    = take_len_ff;
      walk_key_in    = walk_key_ff;
      fin_time_in    = fin_time_ff;
      read_ok_in     = read_ok_ff;
      cmd_pop        = 1'b0;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_wdata      = '0;
      out_load       = 1'b0;
      out_status     = ntr_pkg::STAT_DONE;
      out_event      = '0;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && (out_free || cmd.op == ntr_pkg::OP_READ
                              || cmd.op == ntr_pkg::OP_FINISH)) begin
               cmd_pop = 1'b1;
               case (cmd.op)
                  ntr_pkg::OP_ON: begin
                     out_load = 1'b1;
                     if (!cmd.key_ok || !room) begin
                        out_status = ntr_pkg::STAT_DROP_CAP;
                     end else begin
                        mem_we         = 1'b1;
                        mem_wdata      = '{cmd.time_ms, cmd.note_key, cmd.note_velocity, 1'b0};
                        event_total_in = event_total_ff + 1'b1;
                        if (newly) begin
                           held_map_in[cmd.note_key] = 1'b1;
                           held_total_in = held_total_ff + 1'b1;
                        end
                        out_status = ntr_pkg::STAT_RECORDED;
                     end
                  end
                  ntr_pkg::OP_OFF: begin
                     out_load = 1'b1;
                     if (!cmd.key_ok || !held) begin
                        out_status = ntr_pkg::STAT_DROP_NOTHELD;
                     end else if (store_full) begin
                        out_status = ntr_pkg::STAT_DROP_CAP;
                     end else begin
                        mem_we         = 1'b1;
                        mem_wdata      = '{cmd.time_ms, cmd.note_key, cmd.note_velocity, 1'b1};
                        event_total_in = event_total_ff + 1'b1;
                        held_map_in[cmd.note_key] = 1'b0;
                        held_total_in  = held_total_ff - 1'b1;
                        take_len_in    = cmd.time_ms;
                        out_status     = ntr_pkg::STAT_RECORDED;
                     end
                  end
                  ntr_pkg::OP_FINISH: begin
                     fin_time_in = cmd.time_ms;
                     walk_key_in = '0;
                     state_in    = (held_total_ff != '0) ? BK_WALK : BK_DONE;
                  end
                  ntr_pkg::OP_CLEAR: begin
                     out_load       = 1'b1;
                     held_map_in    = '0;
                     held_total_in  = '0;
                     event_total_in = '0;
                     take_len_in    = '0;
                  end
                  ntr_pkg::OP_READ: begin
                     mem_re     = 1'b1;
                     read_ok_in = in_range;
                     state_in   = BK_READ;
                  end
                  default: begin
                     out_load = 1'b1;
                  end
               endcase
            end
         end
         BK_READ: begin
            if (out_free) begin
               out_load = 1'b1;
               if (read_ok_ff) begin
                  out_status = ntr_pkg::STAT_RECORDED;
                  out_event  = rd_data_ff;
               end else begin
                  out_status = ntr_pkg::STAT_READ_RANGE;
               end
               state_in = BK_IDLE;
            end
         end
         BK_WALK: begin
            if (held_map_ff[walk_key_ff] && !store_full) begin
               mem_we         = 1'b1;
               mem_wdata      = '{fin_time_ff, walk_key_ff, '0, 1'b1};
               event_total_in = event_total_ff + 1'b1;
            end
            if (walk_key_ff == ntr_pkg::KEY_W'(ntr_pkg::KEY_COUNT - 1)) begin
               state_in = BK_DONE;
            end else begin
               walk_key_in = walk_key_ff + 1'b1;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               if (held_total_ff != '0) begin
                  take_len_in = fin_time_ff;
               end
               held_map_in   = '0;
               held_total_in = '0;
               state_in      = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= BK_IDLE;
         held_map_ff    <= '0;
         held_total_ff  <= '0;
         event_total_ff <= '0;
         take_len_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         held_map_ff    <= held_map_in;
         held_total_ff  <= held_total_in;
         event_total_ff <= event_total_in;
         take_len_ff    <= take_len_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      walk_key_ff <= walk_key_in;
      fin_time_ff <= fin_time_in;
      read_ok_ff  <= read_ok_in;
      if (out_load) begin
         status_ff <= out_status;
         count_ff  <= 11'(event_total_in);
         take_ff   <= take_len_in;
         rev_ff    <= out_event;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_stored_count   = count_ff;
   assign rsp_take_length_ms = take_ff;
   assign rsp_read_time      = rev_ff.time_ms;
   assign rsp_read_key       = rev_ff.note_key;
   assign rsp_read_velocity  = rev_ff.note_velocity;
   assign rsp_read_is_off    = rev_ff.is_off;

endmodule

/* sv/note_take_recorder.sv */
`timescale 1ns / 1ps
// Top level of the note take recorder: joins the request front end and the execution back end.
// Depends on ntr_pkg, ntr_front and ntr_back.
//
// The recorder stores note-on and note-off requests of one take in a 1024-entry event
// memory and tracks held keys. Every request gets exactly one response, in order. The front
// end queues up to two decoded requests, so requests are taken while a response waits.
// Note-on, note-off, clear and unused modes are handled in the idle state; a read passes
// through a read state because the event memory has a registered read port; when any key is
// held, finish steps through all 128 keys one per cycle, writing one closing note-off per
// held key, before answering from a done state. The memory needs no clearing after reset.
module note_take_recorder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [6:0]  req_note_key,
   input  logic [6:0]  req_note_velocity,
   input  logic [31:0] req_time_ms,
   input  logic [9:0]  req_read_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [10:0] rsp_stored_count,
   output logic [31:0] rsp_take_length_ms,
   output logic [31:0] rsp_read_time,
   output logic [6:0]  rsp_read_key,
   output logic [6:0]  rsp_read_velocity,
   output logic        rsp_read_is_off
);

   logic             cmd_valid;
   logic             cmd_pop;
   ntr_pkg::cmd_type cmd;

   ntr_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_note_key      (req_note_key),
      .req_note_velocity (req_note_velocity),
      .req_time_ms       (req_time_ms),
      .req_read_index    (req_read_index),
      .cmd_valid         (cmd_valid),
      .cmd_pop           (cmd_pop),
      .cmd               (cmd)
   );

   ntr_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_valid          (cmd_valid),
      .cmd_pop            (cmd_pop),
      .cmd                (cmd),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_stored_count   (rsp_stored_count),
      .rsp_take_length_ms (rsp_take_length_ms),
      .rsp_read_time      (rsp_read_time),
      .rsp_read_key       (rsp_read_key),
      .rsp_read_velocity  (rsp_read_velocity),
      .rsp_read_is_off    (rsp_read_is_off)
   );

endmodule

/* sv/ntr_checker.sv */
`timescale 1ns / 1ps
// Port-level checker of the note take recorder and the bind that attaches it.
// Depends on ntr_pkg and note_take_recorder.
module ntr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic [10:0] rsp_stored_count,
   input logic [31:0] rsp_read_time,
   input logic [6:0]  rsp_read_key,
   input logic [6:0]  rsp_read_velocity,
   input logic        rsp_read_is_off
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Response valid right after reset.");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
                                 && $stable(rsp_stored_count))
      else $error("Stalled response changed or was dropped.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_stored_count <= 11'(ntr_pkg::MAX_EVENTS))
      else $error("Stored count exceeds capacity.");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ntr_pkg::STAT_RECORDED |->
         rsp_read_time == '0 && rsp_read_key == '0
         && rsp_read_velocity == '0 && !rsp_read_is_off)
      else $error("Read fields not zero on a response without a read.");

endmodule

bind note_take_recorder ntr_checker u_ntr_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_stored_count  (rsp_stored_count),
   .rsp_read_time     (rsp_read_time),
   .rsp_read_key      (rsp_read_key),
   .rsp_read_velocity (rsp_read_velocity),
   .rsp_read_is_off   (rsp_read_is_off)
);
